### rtl/core/lfpk_pkg.sv
// Package: widths, CORDIC constants and shared types for the leg foot kinematics block.
package lfpk_pkg;

  localparam int CordicSteps = 16;
  localparam int AtanLen     = 24;
  localparam int AngW        = 16;
  localparam int LenW        = 14;
  localparam int OutW        = 19;
  localparam int ZW          = 34;   // Q29 angle plus wrap headroom
  localparam int XW          = 33;   // Q30 CORDIC x/y
  localparam int TrigW       = 18;   // Q16 sine/cosine
  localparam int QDepth      = 4;
  localparam int QPtrW       = 2;

  localparam logic signed [ZW-1:0] PiQ29     = 34'sd1686629713;
  localparam logic signed [ZW-1:0] TwoPiQ29  = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HalfPiQ29 = 34'sd843314857;
  localparam logic signed [XW-1:0] GainQ30   = 33'sd652032874;
  localparam logic signed [OutW-1:0] OutMax  = 19'sd262143;
  localparam logic signed [OutW-1:0] OutMin  = -19'sd262143 - 19'sd1;

  typedef enum logic [0:0] {
    REG_UPPER = 1'b0,
    REG_LOWER = 1'b1
  } reg_idx_e;

  function automatic logic signed [ZW-1:0] atan_lut(input int i);
    logic signed [ZW-1:0] t;
    begin
      case (i)
        0: t = 34'sd421657428;   1: t = 34'sd248918915;   2: t = 34'sd131521918;
        3: t = 34'sd66762579;    4: t = 34'sd33510843;    5: t = 34'sd16771758;
        6: t = 34'sd8387925;     7: t = 34'sd4194219;     8: t = 34'sd2097141;
        9: t = 34'sd1048575;     10: t = 34'sd524288;     11: t = 34'sd262144;
        12: t = 34'sd131072;     13: t = 34'sd65536;      14: t = 34'sd32768;
        15: t = 34'sd16384;      16: t = 34'sd8192;       17: t = 34'sd4096;
        18: t = 34'sd2048;       19: t = 34'sd1024;       20: t = 34'sd512;
        21: t = 34'sd256;        22: t = 34'sd128;        default: t = 34'sd64;
      endcase
      return t;
    end
  endfunction

  // angles entering the CORDIC bank, already widened to Q13 (17 bits)
  typedef struct packed {
    logic signed [AngW:0]   a_s1;
    logic signed [AngW:0]   a_s2;
    logic signed [AngW:0]   a_t;
    logic signed [AngW:0]   a_r;
    logic signed [AngW:0]   a_p;
    logic signed [AngW:0]   a_y;
    logic signed [AngW-1:0] ox;
    logic signed [AngW-1:0] oy;
    logic signed [AngW-1:0] oz;
  } lfpk_item_t;

endpackage

### rtl/core/lfpk_front.sv
// Front end: accepts items, forms joint angle differences and queues them.
module lfpk_front import lfpk_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [AngW-1:0] hip_i,
  input  logic signed [AngW-1:0] knee_i,
  input  logic signed [AngW-1:0] turn_i,
  input  logic signed [AngW-1:0] ox_i,
  input  logic signed [AngW-1:0] oy_i,
  input  logic signed [AngW-1:0] oz_i,
  input  logic signed [AngW-1:0] roll_i,
  input  logic signed [AngW-1:0] pitch_i,
  input  logic signed [AngW-1:0] yaw_i,
  output logic                   q_valid_o,
  input  logic                   q_ready_i,
  output lfpk_item_t             q_item_o
);

  lfpk_item_t     mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QPtrW:0]   cnt_q;
  logic push, pop;
  lfpk_item_t w;

  always_comb begin
    w.a_s1 = -{hip_i[AngW-1], hip_i};
    w.a_s2 = {knee_i[AngW-1], knee_i} - {hip_i[AngW-1], hip_i};
    w.a_t  = {turn_i[AngW-1], turn_i};
    w.a_r  = {roll_i[AngW-1], roll_i};
    w.a_p  = {pitch_i[AngW-1], pitch_i};
    w.a_y  = {yaw_i[AngW-1], yaw_i};
    w.ox   = ox_i;
    w.oy   = oy_i;
    w.oz   = oz_i;
  end

  assign in_ready_o = (cnt_q != (QPtrW+1)'(QDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;
  assign q_item_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPtrW+1)'(QDepth)) else $error("queue overflow");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q - rp_q) == cnt_q[QPtrW-1:0]) else $error("queue pointers");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (QPtrW+1)'(QDepth) && !pop) |=> !in_ready_o) else $error("full");

endmodule

### rtl/core/lfpk_cordic.sv
// Pipelined rotation-mode CORDIC: one angle per cycle while en_i is high, Q16 sine and cosine out.
module lfpk_cordic import lfpk_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AngW:0]    ang_i,
  output logic signed [TrigW-1:0] sin_o,
  output logic signed [TrigW-1:0] cos_o
);

  logic signed [XW-1:0] x_q [CordicSteps+1];
  logic signed [XW-1:0] y_q [CordicSteps+1];
  logic signed [ZW-1:0] z_q [CordicSteps+1];
  logic                 n_q [CordicSteps+1];
  logic signed [ZW-1:0] z0, zw;
  logic neg0;

  // wrap into [-pi, pi], then fold beyond +-pi/2
  always_comb begin
    z0 = ZW'(ang_i) <<< 16;
    zw = z0;
    if (z0 > PiQ29) zw = z0 - TwoPiQ29;
    else if (z0 < -PiQ29) zw = z0 + TwoPiQ29;
    neg0 = 1'b0;
    if (zw > HalfPiQ29) begin
      zw = zw - PiQ29; neg0 = 1'b1;
    end else if (zw < -HalfPiQ29) begin
      zw = zw + PiQ29; neg0 = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= GainQ30; y_q[0] <= '0; z_q[0] <= zw; n_q[0] <= neg0;
      for (int i = 0; i < CordicSteps; i++) begin
        n_q[i+1] <= n_q[i];
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_lut(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_lut(i);
        end
      end
    end
  end

  logic signed [XW-1:0] xr, yr;
  always_comb begin
    xr = (x_q[CordicSteps] + XW'(8192)) >>> 14;
    yr = (y_q[CordicSteps] + XW'(8192)) >>> 14;
    sin_o = n_q[CordicSteps] ? -TrigW'(yr) : TrigW'(yr);
    cos_o = n_q[CordicSteps] ? -TrigW'(xr) : TrigW'(xr);
  end

endmodule

### rtl/core/lfpk_back.sv
// Back end: CORDIC bank, body point, rotation matrix, world point and output register.
module lfpk_back import lfpk_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [LenW-1:0]        l0_i,
  input  logic [LenW-1:0]        l1_i,
  input  logic                   q_valid_i,
  output logic                   q_ready_o,
  input  lfpk_item_t             q_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [OutW-1:0] wx_o,
  output logic signed [OutW-1:0] wy_o,
  output logic signed [OutW-1:0] wz_o
);

  // stages: 1 entry reg + CordicSteps + 4 math stages (C..F) -> output
  localparam int Lat = CordicSteps + 1 + 4;
  logic [Lat-1:0] v_q;
  logic en;
  logic ov_q;
  // pipeline advances when last stage empty or output register frees
  assign en = !(v_q[Lat-1] && ov_q && !out_ready_i);
  assign q_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en) v_q <= {v_q[Lat-2:0], q_valid_i};
  end

  logic signed [TrigW-1:0] s1, c1, s2, c2, st, ct, sr, cr, sp, cp, sy, cy;
  lfpk_cordic u_c1 (.clk_i, .en_i(en), .ang_i(q_item_i.a_s1), .sin_o(s1), .cos_o(c1));
  lfpk_cordic u_c2 (.clk_i, .en_i(en), .ang_i(q_item_i.a_s2), .sin_o(s2), .cos_o(c2));
  lfpk_cordic u_ct (.clk_i, .en_i(en), .ang_i(q_item_i.a_t), .sin_o(st), .cos_o(ct));
  lfpk_cordic u_cr (.clk_i, .en_i(en), .ang_i(q_item_i.a_r), .sin_o(sr), .cos_o(cr));
  lfpk_cordic u_cp (.clk_i, .en_i(en), .ang_i(q_item_i.a_p), .sin_o(sp), .cos_o(cp));
  lfpk_cordic u_cy (.clk_i, .en_i(en), .ang_i(q_item_i.a_y), .sin_o(sy), .cos_o(cy));

  // offsets ride alongside the CORDIC pipeline
  logic signed [AngW-1:0] ox_q [CordicSteps+1];
  logic signed [AngW-1:0] oy_q [CordicSteps+1];
  logic signed [AngW-1:0] oz_q [CordicSteps+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q[0] <= q_item_i.ox; oy_q[0] <= q_item_i.oy; oz_q[0] <= q_item_i.oz;
      for (int k = 1; k < CordicSteps + 1; k++) begin
        ox_q[k] <= ox_q[k-1]; oy_q[k] <= oy_q[k-1]; oz_q[k] <= oz_q[k-1];
      end
    end
  end
  // CORDIC outputs valid at index CordicSteps; offsets indexed the same

  function automatic logic signed [TrigW-1:0] m16(input logic signed [TrigW-1:0] a,
                                                  input logic signed [TrigW-1:0] b);
    logic signed [2*TrigW-1:0] p;
    begin
      p = (2*TrigW)'(a) * (2*TrigW)'(b) + (2*TrigW)'(32768);
      return TrigW'(p >>> 16);
    end
  endfunction

  // stage C: link products, rotation partials
  localparam int RW = 34;  // reach etc.
  logic signed [RW-1:0] reach_q, zl_q;
  logic signed [TrigW-1:0] st_q, ct_q, srsp_q, spcr_q, sr_q, cr_q, sp_q, cp_q, sy_q, cy_q;
  logic signed [AngW-1:0] oxc_q, oyc_q, ozc_q;
  logic signed [RW-1:0] l0s, l1s;
  always_comb begin
    l0s = RW'($signed({1'b0, l0_i}));
    l1s = RW'($signed({1'b0, l1_i}));
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      reach_q <= l0s * RW'(s1) + l1s * RW'(s2);
      zl_q    <= l0s * RW'(c1) + l1s * RW'(c2);
      st_q <= st; ct_q <= ct;
      srsp_q <= m16(sr, sp); spcr_q <= m16(sp, cr);
      sr_q <= sr; cr_q <= cr; sp_q <= sp; cp_q <= cp; sy_q <= sy; cy_q <= cy;
      oxc_q <= ox_q[CordicSteps]; oyc_q <= oy_q[CordicSteps]; ozc_q <= oz_q[CordicSteps];
    end
  end

  // stage D: body point and matrix
  localparam int PW = 40;
  logic signed [PW-1:0] px_q, py_q, pz_q;
  logic signed [TrigW-1:0] r_q [9];
  logic signed [RW+TrigW-1:0] prx, pry;
  always_comb begin
    prx = (RW+TrigW)'(reach_q) * (RW+TrigW)'(st_q) + (RW+TrigW)'(32768);
    pry = (RW+TrigW)'(reach_q) * (RW+TrigW)'(ct_q) + (RW+TrigW)'(32768);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= -PW'(prx >>> 16) + (PW'(oxc_q) <<< 16);
      py_q <=  PW'(pry >>> 16) + (PW'(oyc_q) <<< 16);
      pz_q <= -PW'(zl_q) + (PW'(ozc_q) <<< 16);
      r_q[0] <= m16(cy_q, cp_q);
      r_q[1] <= m16(cy_q, srsp_q) - m16(sy_q, cr_q);
      r_q[2] <= m16(sy_q, sr_q) + m16(cy_q, spcr_q);
      r_q[3] <= m16(sy_q, cp_q);
      r_q[4] <= m16(cy_q, cr_q) + m16(sy_q, srsp_q);
      r_q[5] <= m16(sy_q, spcr_q) - m16(cy_q, sr_q);
      r_q[6] <= -sp_q;
      r_q[7] <= m16(cp_q, sr_q);
      r_q[8] <= m16(cp_q, cr_q);
    end
  end

  // stage E: nine products
  localparam int MW = PW + TrigW;
  logic signed [MW-1:0] m_q [9];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m_q[3*k]   <= MW'(r_q[3*k])   * MW'(px_q);
        m_q[3*k+1] <= MW'(r_q[3*k+1]) * MW'(py_q);
        m_q[3*k+2] <= MW'(r_q[3*k+2]) * MW'(pz_q);
      end
    end
  end

  // stage F: sums, round and saturate
  function automatic logic signed [OutW-1:0] fin(input logic signed [MW+1:0] v);
    logic signed [MW+1:0] r;
    begin
      r = (v + (MW+2)'(64'sd2147483648)) >>> 32;
      if (r > (MW+2)'(OutMax)) return OutMax;
      if (r < (MW+2)'(OutMin)) return OutMin;
      return OutW'(r);
    end
  endfunction
  logic signed [OutW-1:0] f_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++)
        f_q[k] <= fin((MW+2)'(m_q[3*k]) + (MW+2)'(m_q[3*k+1]) + (MW+2)'(m_q[3*k+2]));
    end
  end

  // output register
  logic ld;
  assign ld = v_q[Lat-1] && (!ov_q || out_ready_i);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (ld) ov_q <= 1'b1;
    else if (out_ready_i) ov_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (ld) begin
      wx_o <= f_q[0]; wy_o <= f_q[1]; wz_o <= f_q[2];
    end
  end
  assign out_valid_o = ov_q;

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q)) else $error("pipe moved during stall");
  a_noloss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[Lat-1] && en) |-> ld) else $error("result dropped");
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld |=> ov_q) else $error("output not loaded");

endmodule

### rtl/core/leg_foot_position_kinematics.sv
// Top level: leg foot position in world frame, with link length registers.
// Usage:
//  Input channel in_valid_i/in_ready_o carries one leg pose item (joint angles,
//  mounting offset, body roll/pitch/yaw). Output channel out_valid_o/out_ready_i
//  carries world_x/y/z, saturated to 19 bits.
//  Link lengths are written via cfg_we_i/cfg_idx_i/cfg_data_i; the user must
//  write them only while idle, which the block does not enforce. Throughput:
//  one item per cycle while the receiver does not stall. Results pass through
//  six parallel pipelined CORDIC units and four math stages (C..F).
//  A four-entry queue decouples input acceptance from the compute pipe.
//  When the receiver stalls, the output register holds and the pipe freezes;
//  the queue keeps accepting until full, then in_ready_o drops.
//  Reset clears the queue, pipe valid bits, output valid and link lengths.
module leg_foot_position_kinematics import lfpk_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [LenW-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [AngW-1:0] hip_angle_i,
  input  logic signed [AngW-1:0] knee_angle_i,
  input  logic signed [AngW-1:0] turn_angle_i,
  input  logic signed [AngW-1:0] offset_x_i,
  input  logic signed [AngW-1:0] offset_y_i,
  input  logic signed [AngW-1:0] offset_z_i,
  input  logic signed [AngW-1:0] roll_angle_i,
  input  logic signed [AngW-1:0] pitch_angle_i,
  input  logic signed [AngW-1:0] yaw_angle_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [OutW-1:0] world_x_o,
  output logic signed [OutW-1:0] world_y_o,
  output logic signed [OutW-1:0] world_z_o
);

  logic [LenW-1:0] l0_q, l1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l0_q <= '0; l1_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_UPPER: l0_q <= cfg_data_i;
        REG_LOWER: l1_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic qv, qr;
  lfpk_item_t qi;

  lfpk_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .hip_i(hip_angle_i), .knee_i(knee_angle_i), .turn_i(turn_angle_i),
    .ox_i(offset_x_i), .oy_i(offset_y_i), .oz_i(offset_z_i),
    .roll_i(roll_angle_i), .pitch_i(pitch_angle_i), .yaw_i(yaw_angle_i),
    .q_valid_o(qv), .q_ready_i(qr), .q_item_o(qi)
  );

  lfpk_back u_back (
    .clk_i, .rst_ni, .l0_i(l0_q), .l1_i(l1_q),
    .q_valid_i(qv), .q_ready_o(qr), .q_item_i(qi),
    .out_valid_o, .out_ready_i,
    .wx_o(world_x_o), .wy_o(world_y_o), .wz_o(world_z_o)
  );

endmodule

### verif/leg_foot_position_kinematics_tb.sv
// Testbench for leg_foot_position_kinematics: directed and random leg poses, checked against a predictor.
module leg_foot_position_kinematics_tb import lfpk_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [AngW-1:0] hip, knee, turn, ox, oy, oz, roll, pitch, yaw;
  } pose_t;

  typedef struct {
    logic signed [OutW-1:0] x, y, z;
  } foot_t;

  localparam longint PiQ29L     = 64'sd1686629713;
  localparam longint TwoPiQ29L  = 64'sd3373259426;
  localparam longint HalfPiQ29L = 64'sd843314857;
  localparam longint GainQ30L   = 64'sd652032874;
  localparam int     SettleCyc  = 40;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic                   cfg_idx_i = REG_UPPER;
  logic [LenW-1:0]        cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic signed [AngW-1:0] hip_angle_i = '0, knee_angle_i = '0, turn_angle_i = '0;
  logic signed [AngW-1:0] offset_x_i = '0, offset_y_i = '0, offset_z_i = '0;
  logic signed [AngW-1:0] roll_angle_i = '0, pitch_angle_i = '0, yaw_angle_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic signed [OutW-1:0] world_x_o, world_y_o, world_z_o;

  leg_foot_position_kinematics dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  longint link_upper, link_lower;
  foot_t  expected_feet[$];
  int     error_count;
  bit     tx_idle_en, rx_idle_en;
  int     rx_hold_req;

  longint atan_tab[CordicSteps] = '{421657428, 248918915, 131521918, 66762579, 33510843,
    16771758, 8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536, 32768, 16384};

  function automatic void cordic_sincos(input longint a13, output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit     flip;
    z = a13 * 65536;
    x = GainQ30L;
    y = 0;
    flip = 0;
    while (z > PiQ29L) z -= TwoPiQ29L;
    while (z < -PiQ29L) z += TwoPiQ29L;
    if (z > HalfPiQ29L) begin
      z -= PiQ29L;
      flip = 1;
    end else if (z < -HalfPiQ29L) begin
      z += PiQ29L;
      flip = 1;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_tab[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_tab[i];
      end
    end
    x = (x + 8192) >>> 14;
    y = (y + 8192) >>> 14;
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic logic signed [OutW-1:0] round_sat(input longint q32);
    longint v;
    v = (q32 + 64'sd2147483648) >>> 32;
    if (v > 262143) v = 262143;
    if (v < -262144) v = -262144;
    return v[OutW-1:0];
  endfunction

  function automatic foot_t predict_foot(input pose_t p);
    longint s1, c1, s2, c2, st, ct, sr, cr, sp, cp, sy, cy, srsp, spcr;
    longint reach, px, py, pz;
    longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
    foot_t  f;
    cordic_sincos(-longint'(p.hip), s1, c1);
    cordic_sincos(longint'(p.knee) - longint'(p.hip), s2, c2);
    cordic_sincos(longint'(p.turn), st, ct);
    reach = link_upper * s1 + link_lower * s2;
    px = -((reach * st + 32768) >>> 16) + longint'(p.ox) * 65536;
    py = ((reach * ct + 32768) >>> 16) + longint'(p.oy) * 65536;
    pz = -(link_upper * c1 + link_lower * c2) + longint'(p.oz) * 65536;
    cordic_sincos(longint'(p.roll), sr, cr);
    cordic_sincos(longint'(p.pitch), sp, cp);
    cordic_sincos(longint'(p.yaw), sy, cy);
    srsp = qmul(sr, sp);
    spcr = qmul(sp, cr);
    r00 = qmul(cy, cp);
    r01 = qmul(cy, srsp) - qmul(sy, cr);
    r02 = qmul(sy, sr) + qmul(cy, spcr);
    r10 = qmul(sy, cp);
    r11 = qmul(cy, cr) + qmul(sy, srsp);
    r12 = qmul(sy, spcr) - qmul(cy, sr);
    r20 = -sp;
    r21 = qmul(cp, sr);
    r22 = qmul(cp, cr);
    f.x = round_sat(r00 * px + r01 * py + r02 * pz);
    f.y = round_sat(r10 * px + r11 * py + r12 * pz);
    f.z = round_sat(r20 * px + r21 * py + r22 * pz);
    return f;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    foot_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_feet.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        want = expected_feet.pop_front();
        if (world_x_o !== want.x) report_mismatch("world_x", world_x_o, want.x);
        if (world_y_o !== want.y) report_mismatch("world_y", world_y_o, want.y);
        if (world_z_o !== want.z) report_mismatch("world_z", world_z_o, want.z);
      end
    end
  end

  // receiver stall control
  int rx_gap;
  always @(posedge clk_i) begin
    if (rx_hold_req > 0) begin
      rx_gap = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_gap > 0) begin
      rx_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni;
      if (rx_idle_en && $urandom_range(0, 3) == 0)
        rx_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
  end

  task automatic send_pose(input pose_t p);
    int gap;
    hip_angle_i <= p.hip;
    knee_angle_i <= p.knee;
    turn_angle_i <= p.turn;
    offset_x_i <= p.ox;
    offset_y_i <= p.oy;
    offset_z_i <= p.oz;
    roll_angle_i <= p.roll;
    pitch_angle_i <= p.pitch;
    yaw_angle_i <= p.yaw;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_feet.push_back(predict_foot(p));
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_feet.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic set_links(input logic [LenW-1:0] upper, input logic [LenW-1:0] lower);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_UPPER;
    cfg_data_i <= upper;
    @(posedge clk_i);
    cfg_idx_i <= REG_LOWER;
    cfg_data_i <= lower;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    link_upper = upper;
    link_lower = lower;
    @(posedge clk_i);
  endtask

  function automatic logic signed [AngW-1:0] rand_angle();
    case ($urandom_range(0, 7))
      0:       return AngW'($urandom);                         // any pattern, wraps
      1:       return AngW'($urandom_range(12860, 12876));     // around +pi/2
      2:       return -AngW'($urandom_range(12860, 12876));
      3:       return AngW'($urandom_range(0, 3000)) - 16'd1500;
      default: return AngW'($urandom_range(0, 51472)) - 16'd25736;
    endcase
  endfunction

  function automatic logic signed [AngW-1:0] rand_offset();
    return ($urandom_range(0, 3) == 0) ? AngW'($urandom)
                                       : AngW'($urandom_range(0, 8000)) - 16'd4000;
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    p.hip = rand_angle();
    p.knee = rand_angle();
    p.turn = rand_angle();
    p.roll = rand_angle();
    p.pitch = rand_angle();
    p.yaw = rand_angle();
    p.ox = rand_offset();
    p.oy = rand_offset();
    p.oz = rand_offset();
    return p;
  endfunction

  function automatic pose_t flat_pose(input logic signed [AngW-1:0] a,
                                      input logic signed [AngW-1:0] o);
    pose_t p;
    p.hip = a; p.knee = a; p.turn = a; p.roll = a; p.pitch = a; p.yaw = a;
    p.ox = o; p.oy = o; p.oz = o;
    return p;
  endfunction

  task automatic test_directed;
    pose_t p;
    logic signed [AngW-1:0] angs[8] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd32767,
                                        16'sh8000, 16'sd12868, -16'sd12868, 16'sd6434};
    tx_idle_en = 0;
    rx_idle_en = 0;
    set_links(LenW'(16383), LenW'(16383));
    foreach (angs[i]) send_pose(flat_pose(angs[i], 16'sd0));
    send_pose(flat_pose(16'sd0, 16'sh7fff));   // offsets at max
    send_pose(flat_pose(16'sd0, 16'sh8000));
    p = flat_pose(16'sd0, 16'sd0);
    p.knee = 16'sd25736;
    p.hip = -16'sd25736;                        // knee-hip beyond pi, wraps
    send_pose(p);
    p.knee = 16'sh8000;
    p.hip = 16'sd32767;
    send_pose(p);
    p = flat_pose(16'sd0, 16'sh7fff);
    p.hip = -16'sd12868;
    p.knee = -16'sd25736;
    send_pose(p);
    p.pitch = 16'sd12868;
    send_pose(p);
    set_links(LenW'(0), LenW'(16383));
    send_pose(flat_pose(16'sd3000, 16'sd100));
    set_links(LenW'(16383), LenW'(0));
    send_pose(flat_pose(-16'sd3000, -16'sd100));
  endtask

  task automatic test_random(input int n);
    tx_idle_en = 1;
    rx_idle_en = 1;
    for (int i = 0; i < n; i++) begin
      if (i % 300 == 150) begin                 // stretch with no idling
        tx_idle_en = 0;
        rx_idle_en = 0;
      end else if (i % 300 == 0) begin
        tx_idle_en = 1;
        rx_idle_en = 1;
      end
      send_pose(rand_pose());
    end
  endtask

  task automatic test_backpressure;
    tx_idle_en = 0;
    rx_idle_en = 0;
    rx_hold_req = 80;
    for (int i = 0; i < 60; i++) send_pose(rand_pose());
  endtask

  initial begin
    error_count = 0;
    link_upper = 0;
    link_lower = 0;
    rx_hold_req = 0;
    rx_gap = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_en = 1;
    rx_idle_en = 1;
    for (int i = 0; i < 10; i++) send_pose(rand_pose());   // links at reset value
    test_directed();
    set_links(LenW'(1600), LenW'(2400));
    test_backpressure();
    test_random(300);
    set_links(LenW'(16383), LenW'(16383));
    test_random(250);
    set_links(LenW'($urandom), LenW'($urandom));
    test_random(250);
    set_links(LenW'(0), LenW'(0));
    test_random(100);
    set_links(LenW'($urandom_range(500, 4000)), LenW'($urandom_range(500, 4000)));
    test_random(150);
    drain();
    if (error_count == 0)
      $display("PASS leg_foot_position_kinematics");
    else
      $display("FAIL leg_foot_position_kinematics");
    $finish;
  end

  initial begin
    #10ms;
    $display("FAIL leg_foot_position_kinematics");
    $finish;
  end

endmodule
